// File: rtl/core/dbla_pkg.sv
// Shared types, constants and helper functions for the draw batch line allocator.
package dbla_pkg;

	// Line store geometry
	localparam int LINES      = 8;
	localparam int LW         = (LINES > 1) ? $clog2(LINES) : 1;
	// Attribute nybbles are summed two per cycle: 16 nybbles in 8 steps
	localparam int NYB_STEPS  = 8;
	localparam int SCAN_STEPS = (LINES > NYB_STEPS) ? LINES : NYB_STEPS;
	localparam int SW         = $clog2(SCAN_STEPS + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VCAP = 2'd0,
		CFG_ICAP = 2'd1,
		CFG_ATTR = 2'd2,
		CFG_ACNT = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] VCAP_RST = 16'd8192;
	localparam logic [15:0] ICAP_RST = 16'd16384;
	localparam logic [4:0]  ACNT_RST = 5'd1;
	localparam logic [4:0]  ACNT_MAX = 5'd16;

	// Result kinds
	typedef enum logic [2:0] {
		K_DRAW    = 3'd0,
		K_ACCEPT  = 3'd1,
		K_TOO_V   = 3'd2,
		K_TOO_I   = 3'd3,
		K_FLUSHED = 3'd4
	} kind_t;

	// Controller -> datapath
	typedef struct packed {
		logic  load;      // latch request, clear scan state
		logic  scan;      // one scan step at idx
		logic  fl_step;   // advance flush index
		logic  use_idx;   // address line store by idx instead of selected line
		logic  emit;      // load output register
		kind_t emit_kind;
		logic  clr_line;  // zero counts of addressed line
		logic  commit;    // advance counts and retag addressed line
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic idx_last;
		logic found;
		logic drawable;
		logic too_v;
		logic too_i;
		logic no_room;
		logic out_free;
	} dp_sts_t;

	// Bytes of one attribute nybble: bits 3..2 type, bits 1..0 size minus one
	function automatic logic [6:0] nybble_bytes(input logic [3:0] nyb);
		logic [2:0] size;
		logic [4:0] sq;
		size = {1'b0, nyb[1:0]} + 3'd1;
		sq   = {2'b00, size} * {2'b00, size};
		case (nyb[3:2])
			2'd0:    nybble_bytes = {2'b00, size, 2'b00};
			2'd1:    nybble_bytes = {2'b00, size, 2'b00};
			2'd2:    nybble_bytes = {1'b0, size, 3'b000};
			default: nybble_bytes = {sq, 2'b00};
		endcase
	endfunction

	// Low three bits of a line number
	function automatic logic [2:0] line_code(input logic [LW-1:0] ln);
		logic [LW+2:0] t;
		t = {3'b000, ln};
		line_code = t[2:0];
	endfunction

endpackage

// File: rtl/core/dbla_ctrl.sv
// Request sequencer for the draw batch line allocator.
module dbla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               command,
	output logic               in_ready,
	output dbla_pkg::dp_cmd_t  cmd,
	input  dbla_pkg::dp_sts_t  sts
);
	import dbla_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DRAW1  = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_ACCEPT = 7'b0010000,
		S_FLUSH  = 7'b0100000,
		S_FDONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.emit_kind = K_DRAW;
		in_ready      = 1'b0;
		state_d       = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = command ? S_FLUSH : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan    = 1'b1;
				cmd.use_idx = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAW1;
				end
			end
			// no tag match: fullest line is drawn first if it is drawable
			S_DRAW1: begin
				if (!sts.found && sts.drawable) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = K_DRAW;
						cmd.clr_line  = 1'b1;
						state_d       = S_CHECK;
					end
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.too_v) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = K_TOO_V;
						state_d       = S_IDLE;
					end
				end else if (sts.too_i) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = K_TOO_I;
						state_d       = S_IDLE;
					end
				end else if (sts.no_room) begin
					if (sts.drawable) begin
						if (sts.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = K_DRAW;
							cmd.clr_line  = 1'b1;
							state_d       = S_ACCEPT;
						end
					end else begin
						cmd.clr_line = 1'b1;
						state_d      = S_ACCEPT;
					end
				end else begin
					state_d = S_ACCEPT;
				end
			end
			S_ACCEPT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = K_ACCEPT;
					cmd.commit    = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_FLUSH: begin
				cmd.use_idx = 1'b1;
				if (sts.drawable) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = K_DRAW;
						cmd.clr_line  = 1'b1;
						cmd.fl_step   = 1'b1;
						if (sts.idx_last) begin
							state_d = S_FDONE;
						end
					end
				end else begin
					cmd.fl_step = 1'b1;
					if (sts.idx_last) begin
						state_d = S_FDONE;
					end
				end
			end
			S_FDONE: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = K_FLUSHED;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/dbla_dp.sv
// Datapath: config registers, line store, scan logic, stride sum and output register.
module dbla_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dbla_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dbla_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [15:0]                       vertex_count,
	input  logic [15:0]                       index_count,
	input  logic [31:0]                       material_id,
	input  dbla_pkg::dp_cmd_t                 cmd,
	output dbla_pkg::dp_sts_t                 sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [2:0]                        kind,
	output logic [2:0]                        line,
	output logic [15:0]                       draw_index_count,
	output logic [31:0]                       draw_material,
	output logic [15:0]                       vertex_base,
	output logic [25:0]                       vertex_byte_offset,
	output logic [16:0]                       index_byte_offset,
	output logic                              last
);
	import dbla_pkg::*;

	// config
	logic [15:0] vcap_q, icap_q;
	logic [63:0] attr_q;
	logic [4:0]  acnt_q;

	// latched request
	logic [15:0] vc_q, ic_q;
	logic [31:0] mat_q;

	// scan state
	logic [SW-1:0] idx_q;
	logic          found_q;
	logic [LW-1:0] match_q, full_q;
	logic [15:0]   vmax_q, imax_q;
	logic [10:0]   stride_q;

	// line store
	logic [31:0] line_mat_q [LINES];
	logic [15:0] line_vtx_q [LINES];
	logic [15:0] line_icnt_q [LINES];

	// output register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [2:0]  line_q;
	logic [15:0] dic_q, vb_q;
	logic [31:0] dmat_q;
	logic [25:0] vbo_q;
	logic [16:0] ibo_q;
	logic        last_q;

	logic [LW-1:0] sel_ln, rd_ln;
	logic [31:0]   rd_mat;
	logic [15:0]   rd_vtx, rd_icnt;
	logic          in_range, nyb_on;
	logic [7:0]    nyb_pair;
	logic [4:0]    eff_cnt, j0, j1;
	logic [6:0]    add0, add1;
	logic [26:0]   prod;
	logic [16:0]   vsum, isum;
	logic          out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcap_q <= VCAP_RST;
			icap_q <= ICAP_RST;
			attr_q <= '0;
			acnt_q <= ACNT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_VCAP: vcap_q <= cfg_data[15:0];
				CFG_ICAP: icap_q <= cfg_data[15:0];
				CFG_ATTR: attr_q <= cfg_data;
				CFG_ACNT: acnt_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vc_q  <= vertex_count;
			ic_q  <= index_count;
			mat_q <= material_id;
		end
	end

	assign sel_ln  = found_q ? match_q : full_q;
	assign rd_ln   = cmd.use_idx ? idx_q[LW-1:0] : sel_ln;
	assign rd_mat  = line_mat_q[rd_ln];
	assign rd_vtx  = line_vtx_q[rd_ln];
	assign rd_icnt = line_icnt_q[rd_ln];

	// stride: two nybbles per scan step
	assign in_range = idx_q < SW'(LINES);
	assign nyb_on   = idx_q < SW'(NYB_STEPS);
	assign nyb_pair = attr_q[{idx_q[2:0], 3'b000} +: 8];
	assign eff_cnt  = (acnt_q > ACNT_MAX) ? ACNT_MAX : acnt_q;
	assign j0       = {1'b0, idx_q[2:0], 1'b0};
	assign j1       = {1'b0, idx_q[2:0], 1'b1};
	assign add0     = (j0 < eff_cnt) ? nybble_bytes(nyb_pair[3:0]) : 7'd0;
	assign add1     = (j1 < eff_cnt) ? nybble_bytes(nyb_pair[7:4]) : 7'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			found_q  <= 1'b0;
			match_q  <= '0;
			full_q   <= '0;
			vmax_q   <= '0;
			imax_q   <= '0;
			stride_q <= '0;
		end else if (cmd.load) begin
			idx_q    <= '0;
			found_q  <= 1'b0;
			match_q  <= '0;
			full_q   <= '0;
			vmax_q   <= '0;
			imax_q   <= '0;
			stride_q <= '0;
		end else begin
			if (cmd.scan || cmd.fl_step) begin
				idx_q <= idx_q + SW'(1);
			end
			if (cmd.scan && in_range) begin
				if (!found_q && rd_mat == mat_q) begin
					found_q <= 1'b1;
					match_q <= idx_q[LW-1:0];
				end
				// last line to raise either running maximum
				if (rd_vtx > vmax_q) begin
					vmax_q <= rd_vtx;
				end
				if (rd_icnt > imax_q) begin
					imax_q <= rd_icnt;
				end
				if (rd_vtx > vmax_q || rd_icnt > imax_q) begin
					full_q <= idx_q[LW-1:0];
				end
			end
			if (cmd.scan && nyb_on) begin
				stride_q <= stride_q + {4'b0000, add0} + {4'b0000, add1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				line_mat_q[i]  <= '0;
				line_vtx_q[i]  <= '0;
				line_icnt_q[i] <= '0;
			end
		end else if (cmd.clr_line) begin
			line_vtx_q[rd_ln]  <= '0;
			line_icnt_q[rd_ln] <= '0;
		end else if (cmd.commit) begin
			line_vtx_q[rd_ln]  <= rd_vtx + vc_q;
			line_icnt_q[rd_ln] <= rd_icnt + ic_q;
			line_mat_q[rd_ln]  <= mat_q;
		end
	end

	assign prod     = {11'b0, rd_vtx} * {16'b0, stride_q};
	assign vsum     = {1'b0, rd_vtx} + {1'b0, vc_q};
	assign isum     = {1'b0, rd_icnt} + {1'b0, ic_q};
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// fields that do not apply to a kind read zero
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.emit_kind;
			line_q <= (cmd.emit_kind == K_FLUSHED) ? 3'd0 : line_code(rd_ln);
			dic_q  <= (cmd.emit_kind == K_DRAW) ? rd_icnt : 16'd0;
			dmat_q <= (cmd.emit_kind == K_DRAW) ? rd_mat : 32'd0;
			vb_q   <= (cmd.emit_kind == K_ACCEPT) ? rd_vtx : 16'd0;
			vbo_q  <= (cmd.emit_kind == K_ACCEPT) ? prod[25:0] : 26'd0;
			ibo_q  <= (cmd.emit_kind == K_ACCEPT) ? {rd_icnt, 1'b0} : 17'd0;
			last_q <= (cmd.emit_kind != K_DRAW);
		end
	end

	assign sts.scan_last = idx_q == SW'(SCAN_STEPS - 1);
	assign sts.idx_last  = idx_q == SW'(LINES - 1);
	assign sts.found     = found_q;
	assign sts.drawable  = (rd_vtx != 16'd0) && (rd_icnt != 16'd0);
	assign sts.too_v     = vc_q > vcap_q;
	assign sts.too_i     = ic_q > icap_q;
	assign sts.no_room   = (vsum > {1'b0, vcap_q}) || (isum > {1'b0, icap_q});
	assign sts.out_free  = out_free;

	assign out_valid          = out_valid_q;
	assign kind               = kind_q;
	assign line               = line_q;
	assign draw_index_count   = dic_q;
	assign draw_material      = dmat_q;
	assign vertex_base        = vb_q;
	assign vertex_byte_offset = vbo_q;
	assign index_byte_offset  = ibo_q;
	assign last               = last_q;

endmodule

// File: rtl/core/draw_batch_line_allocator.sv
// Top level of the draw batch line allocator: sequencer plus datapath.
//
// Channel   Handshake               Payload
// in        in_valid / in_ready     command, vertex_count, index_count, material_id
// out       out_valid / out_ready   kind, line, draw_index_count, draw_material,
//                                   vertex_base, vertex_byte_offset,
//                                   index_byte_offset, last
// cfg       cfg_we (no wait)        cfg_index, cfg_data
//
// Add: the request is accepted, then scanned (one line tag/count read and two attribute nybbles
//   per cycle, until every line and nybble is covered), then come the optional fullest-line draw,
//   the capacity/room check and the accept result; a rejection ends at the check.
// Flush: accepted, then one line per cycle (a drawable line waits for a free output), then flush done.
// A held output transaction stalls the sequencer only when it has a new result to
//   load; the final result sits in the output register while the next request is taken.
// Reset clears all lines to tag 0 and zero counts and loads the config defaults.
module draw_batch_line_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             command,
	input  logic [15:0]                      vertex_count,
	input  logic [15:0]                      index_count,
	input  logic [31:0]                      material_id,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       kind,
	output logic [2:0]                       line,
	output logic [15:0]                      draw_index_count,
	output logic [31:0]                      draw_material,
	output logic [15:0]                      vertex_base,
	output logic [25:0]                      vertex_byte_offset,
	output logic [16:0]                      index_byte_offset,
	output logic                             last,
	input  logic                             cfg_we,
	input  logic [dbla_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dbla_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dbla_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: one request at a time; an add is scanned, decided and reported, a flush goes line by line
	dbla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// line store, stride accumulator, capacity compares, output register
	dbla_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.vertex_count       (vertex_count),
		.index_count        (index_count),
		.material_id        (material_id),
		.cmd                (cmd),
		.sts                (sts),
		.out_ready          (out_ready),
		.out_valid          (out_valid),
		.kind               (kind),
		.line               (line),
		.draw_index_count   (draw_index_count),
		.draw_material      (draw_material),
		.vertex_base        (vertex_base),
		.vertex_byte_offset (vertex_byte_offset),
		.index_byte_offset  (index_byte_offset),
		.last               (last)
	);

`ifndef SYNTHESIS
	// draws are never final; every other result closes its request
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != K_DRAW)))
		else $error("last flag does not match result kind");

	// flush done always reports line 0
	a_flush_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == K_FLUSHED) |-> (line == 3'd0))
		else $error("flush done with nonzero line");

	// one request in flight: no new transaction right after one is taken
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after an input transaction");
`endif

endmodule

// File: test/draw_batch_line_allocator_test.sv
// Self-checking testbench for the draw batch line allocator.
`timescale 1ns / 1ps

module draw_batch_line_allocator_test;
	import dbla_pkg::*;

	// One request as offered on the input channel
	typedef struct packed {
		logic        cmd;
		logic [15:0] vc;
		logic [15:0] ic;
		logic [31:0] mat;
	} draw_batch_t;

	// One result as seen on the output channel
	typedef struct packed {
		kind_t       kind;
		logic [2:0]  ln;
		logic [15:0] dic;
		logic [31:0] dmat;
		logic [15:0] vbase;
		logic [25:0] vbo;
		logic [16:0] ibo;
		logic        lst;
	} alloc_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  command = 1'b0;
	logic [15:0]           vertex_count = '0;
	logic [15:0]           index_count = '0;
	logic [31:0]           material_id = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            kind;
	logic [2:0]            line;
	logic [15:0]           draw_index_count;
	logic [31:0]           draw_material;
	logic [15:0]           vertex_base;
	logic [25:0]           vertex_byte_offset;
	logic [16:0]           index_byte_offset;
	logic                  last;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	draw_batch_line_allocator i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (command),
		.vertex_count       (vertex_count),
		.index_count        (index_count),
		.material_id        (material_id),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.kind               (kind),
		.line               (line),
		.draw_index_count   (draw_index_count),
		.draw_material      (draw_material),
		.vertex_base        (vertex_base),
		.vertex_byte_offset (vertex_byte_offset),
		.index_byte_offset  (index_byte_offset),
		.last               (last),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stimulus waiting to go out, and results the line store says must come back
	draw_batch_t   batches_to_send[$];
	alloc_result_t results_due[$];
	draw_batch_t   offered;
	int            mismatches = 0;

	// Knobs set by the sequence below, always between clock edges
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_cycles = 0;

	// Shadow of the allocator: line store and register file
	logic [31:0] line_tag[LINES];
	logic [15:0] line_vtx[LINES];
	logic [15:0] line_idx[LINES];
	logic [15:0] cap_v = VCAP_RST;
	logic [15:0] cap_i = ICAP_RST;
	logic [63:0] attr_word = '0;
	logic [4:0]  attr_cnt = ACNT_RST;

	initial begin
		for (int i = 0; i < LINES; i++) begin
			line_tag[i] = '0;
			line_vtx[i] = '0;
			line_idx[i] = '0;
		end
	end

	// Vertex stride in bytes: sum over the first attr_cnt nybbles, capped at 16
	function automatic logic [10:0] stride_bytes(input logic [63:0] word, input logic [4:0] cnt);
		logic [10:0] total;
		logic [3:0]  nyb;
		logic [10:0] sz;
		int          n;
		total = '0;
		n = (cnt > 5'd16) ? 16 : int'(cnt);
		for (int i = 0; i < 16; i++) begin
			if (i < n) begin
				nyb = word[i*4 +: 4];
				sz = 11'(nyb[1:0]) + 11'd1;
				case (nyb[3:2])
					2'd0, 2'd1: total += sz * 11'd4;   // int / float, 4 bytes each
					2'd2:       total += sz * 11'd8;   // double
					default:    total += sz * sz * 11'd4; // square float matrix
				endcase
			end
		end
		return total;
	endfunction

	function automatic void push_result(input kind_t k, input logic [2:0] ln,
			input logic [15:0] dic, input logic [31:0] dmat, input logic [15:0] vb,
			input logic [25:0] vbo, input logic [16:0] ibo, input logic lst);
		alloc_result_t r;
		r.kind = k;
		r.ln = ln;
		r.dic = dic;
		r.dmat = dmat;
		r.vbase = vb;
		r.vbo = vbo;
		r.ibo = ibo;
		r.lst = lst;
		results_due.push_back(r);
	endfunction

	// A line is only drawn when both counts are nonzero; drawing empties it
	task automatic emit_draw(input int ln, output logic drew);
		drew = (line_vtx[ln] != 16'd0) && (line_idx[ln] != 16'd0);
		if (drew) begin
			push_result(K_DRAW, 3'(ln), line_idx[ln], line_tag[ln], '0, '0, '0, 1'b0);
			line_vtx[ln] = '0;
			line_idx[ln] = '0;
		end
	endtask

	// Work out every result one accepted request causes, in order
	task automatic predict_request(input draw_batch_t b);
		int          ln;
		logic        found;
		logic        drew;
		logic [15:0] vmax;
		logic [15:0] imax;
		logic [15:0] base;
		logic [15:0] ibase;
		logic [41:0] vbytes;
		ln = 0;
		found = 1'b0;
		if (b.cmd) begin
			for (int i = 0; i < LINES; i++)
				emit_draw(i, drew);
			push_result(K_FLUSHED, '0, '0, '0, '0, '0, '0, 1'b1);
			return;
		end
		for (int i = 0; i < LINES; i++) begin
			if (!found && line_tag[i] == b.mat) begin
				ln = i;
				found = 1'b1;
			end
		end
		// No tag hit: last line to raise either running maximum, drawn right away if drawable
		if (!found) begin
			vmax = '0;
			imax = '0;
			for (int i = 0; i < LINES; i++) begin
				if (line_vtx[i] > vmax) begin
					vmax = line_vtx[i];
					ln = i;
				end
				if (line_idx[i] > imax) begin
					imax = line_idx[i];
					ln = i;
				end
			end
			emit_draw(ln, drew);
		end
		// Oversize check comes after the fullest-line draw; vertices win a tie
		if (b.vc > cap_v) begin
			push_result(K_TOO_V, 3'(ln), '0, '0, '0, '0, '0, 1'b1);
			return;
		end
		if (b.ic > cap_i) begin
			push_result(K_TOO_I, 3'(ln), '0, '0, '0, '0, '0, 1'b1);
			return;
		end
		// No room (also a capacity lowered under the count): draw, or silently clear
		if (({1'b0, line_vtx[ln]} + {1'b0, b.vc}) > {1'b0, cap_v} ||
				({1'b0, line_idx[ln]} + {1'b0, b.ic}) > {1'b0, cap_i}) begin
			emit_draw(ln, drew);
			if (!drew) begin
				line_vtx[ln] = '0;
				line_idx[ln] = '0;
			end
		end
		base = line_vtx[ln];
		ibase = line_idx[ln];
		vbytes = base * stride_bytes(attr_word, attr_cnt);
		push_result(K_ACCEPT, 3'(ln), '0, '0, base, vbytes[25:0], {ibase, 1'b0}, 1'b1);
		line_vtx[ln] = line_vtx[ln] + b.vc;
		line_idx[ln] = line_idx[ln] + b.ic;
		line_tag[ln] = b.mat;
	endtask

	// Input driver: new transaction only once the previous one is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_request(offered);
			if (!in_valid || in_ready) begin
				if (batches_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					offered = batches_to_send.pop_front();
					in_valid <= 1'b1;
					command <= offered.cmd;
					vertex_count <= offered.vc;
					index_count <= offered.ic;
					material_id <= offered.mat;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted down on its own
	always @(posedge clk) begin
		if (rx_hold_cycles > 0)
			rx_hold_cycles <= rx_hold_cycles - 1;
	end

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Output monitor: every result transaction checked against the oldest one due
	always @(posedge clk) begin : monitor
		alloc_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result transaction with none due: kind %0d line %0d", kind, line);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", 64'(want.kind), 64'(kind));
					check_field("line", 64'(want.ln), 64'(line));
					check_field("draw_index_count", 64'(want.dic), 64'(draw_index_count));
					check_field("draw_material", 64'(want.dmat), 64'(draw_material));
					check_field("vertex_base", 64'(want.vbase), 64'(vertex_base));
					check_field("vertex_byte_offset", 64'(want.vbo), 64'(vertex_byte_offset));
					check_field("index_byte_offset", 64'(want.ibo), 64'(index_byte_offset));
					check_field("last", 64'(want.lst), 64'(last));
				end
			end
			out_ready <= (rx_hold_cycles == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Register write; only ever called with nothing in flight
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_VCAP: cap_v = data[15:0];
			CFG_ICAP: cap_i = data[15:0];
			CFG_ATTR: attr_word = data;
			CFG_ACNT: attr_cnt = data[4:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (batches_to_send.size() != 0 || in_valid || results_due.size() != 0);
	endtask

	function automatic void queue_batch(input logic cmd, input logic [15:0] vc,
			input logic [15:0] ic, input logic [31:0] mat);
		draw_batch_t b;
		b.cmd = cmd;
		b.vc = vc;
		b.ic = ic;
		b.mat = mat;
		batches_to_send.push_back(b);
	endfunction

	// Counts mostly well under capacity so lines fill up over several adds
	function automatic logic [15:0] pick_count(input logic [15:0] cap);
		int r;
		int c;
		r = $urandom_range(99);
		if (r < 10)
			c = 0;
		else if (r < 70)
			c = $urandom_range(1, cap / 8 + 1);
		else if (r < 85)
			c = $urandom_range(cap / 2, cap);
		else if (r < 93)
			c = cap + $urandom_range(0, 2);
		else
			c = $urandom_range(0, 65535);
		if (c > 65535)
			c = 65535;
		return 16'(c);
	endfunction

	// Small tag pool keeps tag hits frequent; the rest force fullest-line reuse
	task automatic queue_random(input int n);
		draw_batch_t b;
		int          r;
		repeat (n) begin
			b.cmd = ($urandom_range(99) < 5);
			b.vc = pick_count(cap_v);
			b.ic = pick_count(cap_i);
			r = $urandom_range(99);
			if (r < 60)
				b.mat = $urandom_range(0, 9);
			else if (r < 70)
				b.mat = '1;
			else
				b.mat = $urandom;
			batches_to_send.push_back(b);
		end
	endtask

	function automatic logic [63:0] junk_high(input logic [15:0] value);
		return ({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000) | 64'(value);
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Phase 1: reset registers (stride 4), no idling, directed cases first
		queue_batch(1'b0, 16'd0, 16'd0, 32'd0);             // empty add on tag 0
		queue_batch(1'b0, 16'd10, 16'd20, 32'd0);
		queue_batch(1'b0, 16'd3, 16'd6, 32'd5);             // miss: fullest line drawn
		queue_batch(1'b0, 16'd8193, 16'd1, 32'd5);          // too many vertices
		queue_batch(1'b0, 16'd1, 16'd16385, 32'd5);         // too many indices
		queue_batch(1'b0, 16'hFFFF, 16'hFFFF, 32'd5);       // both over: vertices reported
		queue_batch(1'b0, 16'd8192, 16'd16384, 32'd7);      // exactly full
		queue_batch(1'b0, 16'd1, 16'd1, 32'd7);             // no room: draw first
		queue_batch(1'b0, 16'd8000, 16'd0, 32'd9);
		queue_batch(1'b0, 16'd500, 16'd0, 32'd9);           // no room, not drawable: cleared
		queue_batch(1'b0, 16'd0, 16'd3, 32'hFFFF_FFFF);     // fullest not drawable
		queue_batch(1'b0, 16'd4, 16'd4, 32'd0);
		queue_batch(1'b0, 16'd5, 16'd5, 32'd0);
		queue_batch(1'b0, 16'd7, 16'd9, 32'h1234_5678);     // fullest by index count
		queue_batch(1'b1, 16'd0, 16'd0, 32'd0);             // flush all
		queue_batch(1'b1, 16'd0, 16'd0, 32'd0);             // flush with nothing to draw
		queue_batch(1'b0, 16'h1555, 16'h2AAA, 32'h5555_5555);
		queue_batch(1'b0, 16'h0AAA, 16'h1555, 32'hAAAA_AAAA);
		queue_batch(1'b0, 16'd1, 16'd1, 32'h8000_0000);
		queue_batch(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		queue_random(40);
		wait_for_drain();

		// Phase 2: small capacities, random attributes, sender idling
		write_reg(CFG_VCAP, junk_high(16'd100));
		write_reg(CFG_ICAP, junk_high(16'd200));
		write_reg(CFG_ATTR, {$urandom, $urandom});
		write_reg(CFG_ACNT, 64'd4);
		tx_idle_pct = 69;
		queue_random(100);
		wait_for_drain();

		// Phase 3: widest stride and capacities; long receiver hold fills the block
		write_reg(CFG_VCAP, 64'hFFFF);
		write_reg(CFG_ICAP, 64'hFFFF);
		write_reg(CFG_ATTR, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_ACNT, 64'd16);
		tx_idle_pct = 0;
		rx_stall_pct = 69;
		rx_hold_cycles = 300;
		queue_random(100);
		wait_for_drain();

		// Phase 4: capacities of one (below what the lines hold), zero stride
		write_reg(CFG_VCAP, 64'd1);
		write_reg(CFG_ICAP, 64'd1);
		write_reg(CFG_ATTR, 64'd0);
		write_reg(CFG_ACNT, 64'd0);
		tx_idle_pct = 13;
		rx_stall_pct = 13;
		queue_random(100);
		wait_for_drain();

		// Phase 5: random capacities, attribute count over sixteen
		write_reg(CFG_VCAP, junk_high(16'($urandom_range(50, 3000))));
		write_reg(CFG_ICAP, junk_high(16'($urandom_range(50, 6000))));
		write_reg(CFG_ATTR, {$urandom, $urandom});
		write_reg(CFG_ACNT, {$urandom, 27'd0, 5'd31});
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		queue_random(60);
		// sender holds until every result is back, then count changes again
		wait_for_drain();
		write_reg(CFG_ACNT, 64'($urandom_range(17, 30)));
		tx_idle_pct = 13;
		rx_stall_pct = 13;
		queue_random(60);
		wait_for_drain();

		// Let any late, unexpected transaction show up
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: ~500 requests plus the receiver hold end well before this timeout
	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
rtl/core/dbla_pkg.sv
rtl/core/dbla_ctrl.sv
rtl/core/dbla_dp.sv
rtl/core/draw_batch_line_allocator.sv
test/draw_batch_line_allocator_test.sv
